// ===== design/tlr_pkg.sv =====
// thick line rasterizer package: field widths, line state and result types
// no dependencies; imported by every module of the block

package tlr_pkg;

    localparam int COORD_BITS = 9;
    localparam int THICK_BITS = 8;
    localparam int COLOR_BITS = 16;
    localparam int WIN_BITS   = 10;
    localparam int COUNT_BITS = 17;
    localparam int DEC_BITS   = COORD_BITS + 4;
    localparam int IN_BITS    = 4 * COORD_BITS + THICK_BITS + COLOR_BITS;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int OUT_BITS   = 4 * WIN_BITS + COUNT_BITS + COLOR_BITS;
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;

    // action codes carried on the input tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [WIN_BITS-1:0]   t_win_coord;

    typedef struct packed {
        t_win_coord col_first;
        t_win_coord row_first;
        t_win_coord col_last;
        t_win_coord row_last;
    } t_window;

    typedef struct packed {
        logic                        straight;
        logic                        major_is_y;
        t_coord                      cur_major;
        t_coord                      cur_minor;
        t_coord                      major_end;
        logic                        minor_neg;
        t_coord                      d_major;
        t_coord                      d_minor;
        logic signed [DEC_BITS-1:0]  decision;
        t_window                     span;
    } t_line;

    typedef struct packed {
        t_window                 win;
        logic [COUNT_BITS-1:0]   count;
        logic                    last;
    } t_result;

endpackage

// ===== design/tlr_line_setup.sv =====
// line setup: straight-span window or bresenham start state from two end points
// depends on tlr_pkg

module tlr_line_setup
    import tlr_pkg::*;
(
    input  t_coord                i_x0,
    input  t_coord                i_y0,
    input  t_coord                i_x1,
    input  t_coord                i_y1,
    input  logic [THICK_BITS-1:0] i_thick,
    output t_line                 o_line
);

    t_coord     adx;
    t_coord     ady;
    t_coord     lo;
    t_coord     hi;
    t_coord     sx0;
    t_coord     sy0;
    t_coord     sx1;
    t_coord     sy1;
    logic       y_major;
    t_win_coord w_minus1;

    always_comb begin
        adx      = (i_x0 > i_x1) ? (i_x0 - i_x1) : (i_x1 - i_x0);
        ady      = (i_y0 > i_y1) ? (i_y0 - i_y1) : (i_y1 - i_y0);
        y_major  = (ady >= adx);
        w_minus1 = WIN_BITS'(i_thick) - WIN_BITS'(1);

        o_line          = '0;
        o_line.straight = (i_x0 == i_x1) || (i_y0 == i_y1);

        // straight span window, ends put in order
        if (i_x0 == i_x1) begin
            lo = (i_y0 < i_y1) ? i_y0 : i_y1;
            hi = (i_y0 < i_y1) ? i_y1 : i_y0;
            o_line.span.col_first = WIN_BITS'(i_x0);
            o_line.span.row_first = WIN_BITS'(lo);
            o_line.span.col_last  = WIN_BITS'(i_x0) + w_minus1;
            o_line.span.row_last  = WIN_BITS'(hi);
        end else begin
            lo = (i_x0 < i_x1) ? i_x0 : i_x1;
            hi = (i_x0 < i_x1) ? i_x1 : i_x0;
            o_line.span.col_first = WIN_BITS'(lo);
            o_line.span.row_first = WIN_BITS'(i_y0);
            o_line.span.col_last  = WIN_BITS'(hi);
            o_line.span.row_last  = WIN_BITS'(i_y0) + w_minus1;
        end

        // swap ends so the run climbs the major axis
        if ((y_major && (i_y0 > i_y1)) || (!y_major && (i_x0 > i_x1))) begin
            sx0 = i_x1; sy0 = i_y1; sx1 = i_x0; sy1 = i_y0;
        end else begin
            sx0 = i_x0; sy0 = i_y0; sx1 = i_x1; sy1 = i_y1;
        end

        o_line.major_is_y = (i_x0 == i_x1) ? 1'b1 : ((i_y0 == i_y1) ? 1'b0 : y_major);
        if (y_major) begin
            o_line.cur_major = sy0;
            o_line.major_end = sy1;
            o_line.cur_minor = sx0;
            o_line.minor_neg = (sx1 < sx0);
            o_line.d_major   = sy1 - sy0;
            o_line.d_minor   = adx;
        end else begin
            o_line.cur_major = sx0;
            o_line.major_end = sx1;
            o_line.cur_minor = sy0;
            o_line.minor_neg = (sy1 < sy0);
            o_line.d_major   = sx1 - sx0;
            o_line.d_minor   = ady;
        end
        o_line.decision = $signed(DEC_BITS'({o_line.d_minor, 1'b0}))
                        - $signed(DEC_BITS'(o_line.d_major));
    end

endmodule

// ===== design/tlr_step_unit.sv =====
// step unit: current window, pixel count and the next bresenham state
// depends on tlr_pkg

module tlr_step_unit
    import tlr_pkg::*;
(
    input  t_line                 i_line,
    input  logic [THICK_BITS-1:0] i_thick,
    output t_result               o_result,
    output t_line                 o_next,
    output logic                  o_done
);

    t_coord                         col;
    t_coord                         row;
    logic                           at_end;
    t_win_coord                     span_len;
    t_win_coord                     mul_b;
    t_win_coord                     w_minus1;
    logic [THICK_BITS+WIN_BITS-1:0] product;
    logic signed [DEC_BITS-1:0]     two_dmin;
    logic signed [DEC_BITS-1:0]     two_dmaj;

    always_comb begin
        col      = i_line.major_is_y ? i_line.cur_minor : i_line.cur_major;
        row      = i_line.major_is_y ? i_line.cur_major : i_line.cur_minor;
        at_end   = (i_line.cur_major == i_line.major_end);
        w_minus1 = WIN_BITS'(i_thick) - WIN_BITS'(1);
        span_len = i_line.major_is_y
                 ? (i_line.span.row_last - i_line.span.row_first + WIN_BITS'(1))
                 : (i_line.span.col_last - i_line.span.col_first + WIN_BITS'(1));

        // one shared multiplier: width by span or width by width
        mul_b   = i_line.straight ? span_len : WIN_BITS'(i_thick);
        product = (THICK_BITS+WIN_BITS)'(i_thick) * (THICK_BITS+WIN_BITS)'(mul_b);

        o_result.count = product[COUNT_BITS-1:0];
        if (i_line.straight) begin
            o_result.win  = i_line.span;
            o_result.last = 1'b1;
        end else begin
            o_result.win.col_first = WIN_BITS'(col);
            o_result.win.row_first = WIN_BITS'(row);
            o_result.win.col_last  = WIN_BITS'(col) + w_minus1;
            o_result.win.row_last  = WIN_BITS'(row) + w_minus1;
            o_result.last          = at_end;
        end
        o_done = i_line.straight || at_end;

        two_dmin = $signed(DEC_BITS'({i_line.d_minor, 1'b0}));
        two_dmaj = $signed(DEC_BITS'({i_line.d_major, 1'b0}));

        o_next          = i_line;
        o_next.straight = 1'b0;
        if (!o_done) begin
            if (i_line.decision > 0) begin
                o_next.cur_minor = i_line.minor_neg ? (i_line.cur_minor - 1'b1)
                                                    : (i_line.cur_minor + 1'b1);
                o_next.decision  = i_line.decision - two_dmaj + two_dmin;
            end else begin
                o_next.decision  = i_line.decision + two_dmin;
            end
            o_next.cur_major = i_line.cur_major + 1'b1;
        end
    end

endmodule

// ===== design/thick_line_rasterizer_top.sv =====
// thick line rasterizer top: input register, line state, output register
// depends on tlr_pkg, tlr_line_setup, tlr_step_unit
// a step transfer's window goes through the input register and then the output register before m_axis shows it
// throughput: one item per cycle; while a window waits on m_axis_tready, loads and idle
// steps keep flowing, a step that makes a window waits in the input register
// reset (i_rst_n low, synchronous) empties both registers and ends any line in progress

module thick_line_rasterizer_top
    import tlr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, end_x, end_y, thickness, pen_color, zero fill
    input  logic [8*IN_BYTES-1:0]  s_axis_tdata,
    // action
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // win_col_first, win_row_first, win_col_last, win_row_last, fill_count,
    // fill_color, zero fill
    output logic [8*OUT_BYTES-1:0] m_axis_tdata,
    // last_window
    output logic                   m_axis_tlast
);

    logic                    r_in_valid;
    logic                    r_in_action;
    logic [IN_BITS-1:0]      r_in_data;
    logic                    r_busy;
    t_line                   r_line;
    logic [THICK_BITS-1:0]   r_thick;
    logic [COLOR_BITS-1:0]   r_color;
    logic                    r_out_valid;
    logic [8*OUT_BYTES-1:0]  r_out_data;
    logic                    r_out_last;

    t_line   setup_line;
    t_line   step_next;
    t_result step_res;
    logic    step_done;
    logic    produce;
    logic    advance;

    tlr_line_setup u_setup (
        .i_x0    (r_in_data[COORD_BITS-1:0]),
        .i_y0    (r_in_data[2*COORD_BITS-1:COORD_BITS]),
        .i_x1    (r_in_data[3*COORD_BITS-1:2*COORD_BITS]),
        .i_y1    (r_in_data[4*COORD_BITS-1:3*COORD_BITS]),
        .i_thick (r_in_data[4*COORD_BITS+THICK_BITS-1:4*COORD_BITS]),
        .o_line  (setup_line)
    );

    tlr_step_unit u_step (
        .i_line   (r_line),
        .i_thick  (r_thick),
        .o_result (step_res),
        .o_next   (step_next),
        .o_done   (step_done)
    );

    assign produce       = (r_in_action == ACT_STEP) && r_busy;
    assign advance       = r_in_valid && (!produce || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_line      <= '0;
            r_thick     <= THICK_BITS'(1);
            r_color     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end

            if (advance) begin
                if (r_in_action == ACT_LOAD) begin
                    r_busy  <= 1'b1;
                    r_line  <= setup_line;
                    r_thick <= r_in_data[4*COORD_BITS+THICK_BITS-1:4*COORD_BITS];
                    r_color <= r_in_data[IN_BITS-1:4*COORD_BITS+THICK_BITS];
                end else if (r_busy) begin
                    r_line <= step_next;
                    r_busy <= !step_done;
                end
            end

            if (advance && produce) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_data   <= s_axis_tdata[IN_BITS-1:0];
        end
        if (advance && produce) begin
            r_out_data <= {(8*OUT_BYTES-OUT_BITS)'(0), r_color, step_res.count,
                           step_res.win.row_last, step_res.win.col_last,
                           step_res.win.row_first, step_res.win.col_first};
            r_out_last <= step_res.last;
        end
    end

    // a straight span is only pending inside an active line
    a_straight_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line.straight |-> r_busy)
        else $error("straight span pending with no active line");

    // input side only stalls while the input register holds an item
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with empty input register");

    // bresenham run never passes its end point
    a_major_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_line.straight) |-> (r_line.cur_major <= r_line.major_end))
        else $error("major coordinate passed line end");

endmodule

// ===== verif/thick_line_rasterizer_top_tb.sv =====
`timescale 1ns / 100ps
// testbench for thick_line_rasterizer_top: directed and random line loads and steps
// depends on tlr_pkg and the rasterizer rtl; a scoreboard class predicts every fill window

module thick_line_rasterizer_top_tb;
    import tlr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int SRC_IDLE [4]   = '{0, 49, 0, 19};
    localparam int SINK_STALL [4] = '{0, 0, 49, 19};

    typedef struct packed {
        t_win_coord            col_first;
        t_win_coord            row_first;
        t_win_coord            col_last;
        t_win_coord            row_last;
        logic [COUNT_BITS-1:0] count;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_fill_window;

    class window_scoreboard;
        logic                  busy;
        logic                  straight;
        logic                  major_y;
        logic                  minor_neg;
        t_coord                cur_major;
        t_coord                cur_minor;
        t_coord                major_end;
        int                    d_major;
        int                    d_minor;
        int                    decision;
        t_window               span;
        logic [THICK_BITS-1:0] thick;
        logic [COLOR_BITS-1:0] color;
        t_fill_window          pending[$];
        int                    errors;

        function new();
            busy      = 1'b0;
            straight  = 1'b0;
            major_y   = 1'b0;
            minor_neg = 1'b0;
            cur_major = '0;
            cur_minor = '0;
            major_end = '0;
            d_major   = 0;
            d_minor   = 0;
            decision  = 0;
            span      = '0;
            thick     = THICK_BITS'(1);
            color     = '0;
            errors    = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("%0t: window mismatch, %s", $time, msg);
        endtask

        // input transfer: latch a line or work out the next window
        function void note_transfer(logic act, logic [8*IN_BYTES-1:0] data);
            t_coord       x0, y0, x1, y1, tmp;
            t_coord       col, row;
            int           adx, ady, len;
            t_fill_window w;
            x0 = data[0 +: COORD_BITS];
            y0 = data[COORD_BITS +: COORD_BITS];
            x1 = data[2*COORD_BITS +: COORD_BITS];
            y1 = data[3*COORD_BITS +: COORD_BITS];
            if (act == ACT_LOAD) begin
                thick    = data[4*COORD_BITS +: THICK_BITS];
                color    = data[4*COORD_BITS+THICK_BITS +: COLOR_BITS];
                busy     = 1'b1;
                straight = (x0 == x1) || (y0 == y1);
                if (x0 == x1) begin
                    major_y        = 1'b1;
                    span.col_first = t_win_coord'(x0);
                    span.row_first = t_win_coord'((y0 < y1) ? y0 : y1);
                    span.col_last  = t_win_coord'(int'(x0) + int'(thick) - 1);
                    span.row_last  = t_win_coord'((y0 < y1) ? y1 : y0);
                end else if (y0 == y1) begin
                    major_y        = 1'b0;
                    span.col_first = t_win_coord'((x0 < x1) ? x0 : x1);
                    span.row_first = t_win_coord'(y0);
                    span.col_last  = t_win_coord'((x0 < x1) ? x1 : x0);
                    span.row_last  = t_win_coord'(int'(y0) + int'(thick) - 1);
                end else begin
                    adx     = (x0 > x1) ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
                    ady     = (y0 > y1) ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
                    major_y = (ady >= adx);
                    // run always climbs the major axis
                    if (major_y ? (y0 > y1) : (x0 > x1)) begin
                        tmp = x0; x0 = x1; x1 = tmp;
                        tmp = y0; y0 = y1; y1 = tmp;
                    end
                    cur_major = major_y ? y0 : x0;
                    major_end = major_y ? y1 : x1;
                    cur_minor = major_y ? x0 : y0;
                    minor_neg = major_y ? (x1 < x0) : (y1 < y0);
                    d_major   = major_y ? ady : adx;
                    d_minor   = major_y ? adx : ady;
                    decision  = 2 * d_minor - d_major;
                end
                return;
            end
            if (!busy)
                return;
            w.color = color;
            if (straight) begin
                len = major_y ? int'(span.row_last) - int'(span.row_first) + 1
                              : int'(span.col_last) - int'(span.col_first) + 1;
                w.col_first = span.col_first;
                w.row_first = span.row_first;
                w.col_last  = span.col_last;
                w.row_last  = span.row_last;
                w.count     = COUNT_BITS'(int'(thick) * len);
                w.last      = 1'b1;
                straight    = 1'b0;
                busy        = 1'b0;
            end else begin
                col         = major_y ? cur_minor : cur_major;
                row         = major_y ? cur_major : cur_minor;
                w.col_first = t_win_coord'(col);
                w.row_first = t_win_coord'(row);
                w.col_last  = t_win_coord'(int'(col) + int'(thick) - 1);
                w.row_last  = t_win_coord'(int'(row) + int'(thick) - 1);
                w.count     = COUNT_BITS'(int'(thick) * int'(thick));
                w.last      = (cur_major == major_end);
                if (w.last) begin
                    busy = 1'b0;
                end else begin
                    if (decision > 0) begin
                        cur_minor = minor_neg ? cur_minor - 1'b1 : cur_minor + 1'b1;
                        decision -= 2 * d_major;
                    end
                    decision += 2 * d_minor;
                    cur_major = cur_major + 1'b1;
                end
            end
            pending.push_back(w);
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s: got %0d, expected %0d", name, got, want));
        endtask

        // output transfer: compare against the oldest predicted window
        task check_window(logic [8*OUT_BYTES-1:0] data, logic last);
            t_fill_window got, want;
            got.col_first = data[0 +: WIN_BITS];
            got.row_first = data[WIN_BITS +: WIN_BITS];
            got.col_last  = data[2*WIN_BITS +: WIN_BITS];
            got.row_last  = data[3*WIN_BITS +: WIN_BITS];
            got.count     = data[4*WIN_BITS +: COUNT_BITS];
            got.color     = data[4*WIN_BITS+COUNT_BITS +: COLOR_BITS];
            got.last      = last;
            if (pending.size() == 0) begin
                report("window transfer with nothing predicted");
                return;
            end
            want = pending.pop_front();
            check_field("win_col_first", 32'(got.col_first), 32'(want.col_first));
            check_field("win_row_first", 32'(got.row_first), 32'(want.row_first));
            check_field("win_col_last", 32'(got.col_last), 32'(want.col_last));
            check_field("win_row_last", 32'(got.row_last), 32'(want.row_last));
            check_field("fill_count", 32'(got.count), 32'(want.count));
            check_field("fill_color", 32'(got.color), 32'(want.color));
            check_field("last_window", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // start_x, start_y, end_x, end_y, thickness, pen_color, zero fill
    logic [8*IN_BYTES-1:0]  s_axis_tdata;
    // action
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // win_col_first, win_row_first, win_col_last, win_row_last, fill_count,
    // fill_color, zero fill
    logic [8*OUT_BYTES-1:0] m_axis_tdata;
    // last_window
    logic                   m_axis_tlast;

    int               src_idle_pct;
    int               sink_stall_pct;
    int               cycle_count;
    window_scoreboard sb;

    thick_line_rasterizer_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_transfer(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_window(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic send_item(logic act, logic [8*IN_BYTES-1:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_load(t_coord sx, t_coord sy, t_coord ex, t_coord ey,
                             logic [THICK_BITS-1:0] w, logic [COLOR_BITS-1:0] c);
        send_item(ACT_LOAD, {(8*IN_BYTES-IN_BITS)'(0), c, w, ey, ex, sy, sx});
    endtask

    // step payload is don't-care, so it carries noise
    task automatic send_step();
        logic [IN_BITS-1:0] junk;
        junk = IN_BITS'({$urandom, $urandom});
        send_item(ACT_STEP, {(8*IN_BYTES-IN_BITS)'(0), junk});
    endtask

    task automatic run_random(int budget);
        int                    sent, kind, mode, n, nsteps, adx, ady;
        t_coord                x0, y0, x1, y1;
        logic [THICK_BITS-1:0] w;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(99);
            x0   = t_coord'($urandom_range(COORD_MAX));
            y0   = t_coord'($urandom_range(COORD_MAX));
            if (kind < 6) begin
                x1 = x0;
                y1 = t_coord'($urandom_range(COORD_MAX));
            end else if (kind < 12) begin
                x1 = t_coord'($urandom_range(COORD_MAX));
                y1 = y0;
            end else if (kind < 15) begin
                x1 = t_coord'($urandom_range(COORD_MAX));
                y1 = t_coord'($urandom_range(COORD_MAX));
            end else begin
                // short lines keep the run cheap
                x1 = t_coord'($urandom_range(int'(x0) > 12 ? int'(x0) - 12 : 0,
                              int'(x0) < COORD_MAX - 12 ? int'(x0) + 12 : COORD_MAX));
                y1 = t_coord'($urandom_range(int'(y0) > 12 ? int'(y0) - 12 : 0,
                              int'(y0) < COORD_MAX - 12 ? int'(y0) + 12 : COORD_MAX));
            end
            w   = ($urandom_range(99) < 30) ? THICK_BITS'($urandom_range(1, 6))
                                            : THICK_BITS'($urandom_range(1, 255));
            adx = (x0 > x1) ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
            ady = (y0 > y1) ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
            n   = (adx == 0 || ady == 0) ? 1 : ((adx > ady) ? adx : ady) + 1;
            send_load(x0, y0, x1, y1, w, COLOR_BITS'($urandom_range(16'hFFFF)));
            sent++;
            mode   = $urandom_range(99);
            // cut some lines short so the next load replaces them
            nsteps = (mode < 8) ? $urandom_range(n - 1) : n;
            repeat (nsteps) send_step();
            sent += nsteps;
            if (mode >= 8 && mode < 16)
                repeat ($urandom_range(1, 2)) send_step();
        end
    endtask

    initial begin
        int wait_cycles;
        sb             = new();
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = ACT_LOAD;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // step with no line loaded
        send_step();
        // single point
        send_load(10, 20, 10, 20, 1, 16'h0000);
        send_step();
        // vertical and horizontal spans given in reverse
        send_load(511, 511, 511, 0, 255, 16'hFFFF);
        send_step();
        send_load(511, 0, 0, 0, 255, 16'hA5A5);
        send_step();
        // zero thickness wraps the window end below zero
        send_load(0, 0, 511, 0, 0, 16'h5A5A);
        send_step();
        // equal deltas go to y
        send_load(0, 0, 2, 2, 2, 16'h0001);
        repeat (3) send_step();
        // x major with falling rows
        send_load(0, 10, 3, 8, 3, 16'h7E0F);
        repeat (4) send_step();
        // reversed x major, replaced halfway by a reversed y major line
        send_load(104, 102, 100, 100, 7, 16'h1234);
        repeat (2) send_step();
        send_load(1, 3, 2, 0, 255, 16'h8000);
        repeat (4) send_step();

        for (int phase = 0; phase < 4; phase++) begin
            src_idle_pct   = SRC_IDLE[phase];
            sink_stall_pct = SINK_STALL[phase];
            run_random(330);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d windows never arrived", sb.pending.size()));
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
